// ===== hw/rtl/ppfb_pkg.sv =====
// Shared constants and command codes for the page-packed pixel frame store.
package ppfb_pkg;

   localparam int STORE_DEPTH       = 1024;
   localparam int STORE_AW          = $clog2(STORE_DEPTH);
   localparam int DATA_W            = 8;
   localparam int COORD_W           = 8;
   localparam int CMD_W             = 2;
   localparam int PAGE_W            = COORD_W - $clog2(DATA_W);
   localparam int IDX_W             = PAGE_W + COORD_W;
   localparam int DEF_PANEL_WIDTH   = 128;
   localparam int DEF_PANEL_HEIGHT  = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_FILL  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

endpackage

// ===== hw/rtl/page_packed_pixel_framebuffer.sv =====
// Page-packed 1bpp frame store: clear, fill-rectangle and byte read commands.
//
// A 1024 x 8 frame store kept in one synchronous RAM. Each byte holds eight
// vertical pixels of one column, top pixel in bit 0, byte index = page *
// PANEL_WIDTH + column. A command beat is taken when start is high and busy
// is low; exactly one result beat follows on rsp_valid / rsp_read_data, held
// for one cycle only, so the receiver must take it when it comes. Rate is set
// by the single RAM port pair: a read passes through the S_READ state and the
// result register; a clear sweeps one byte a cycle; an unused command code or
// an empty rectangle answers in the cycle after its command beat. A fill walks
// the rectangle column by column and, within a column, one page at a time: it
// sets up each column in S_COL, then for every page it touches on the panel
// reads in S_PAGE and modifies and writes in S_WR; a page it touches off the
// panel takes S_PAGE only. Columns off the panel take S_COL only. After reset
// the block runs a clearing pass over the store with busy high, before the
// first command beat is taken; no result beat is produced for that pass.
module page_packed_pixel_framebuffer #(
   parameter int PANEL_WIDTH  = ppfb_pkg::DEF_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = ppfb_pkg::DEF_PANEL_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [ppfb_pkg::CMD_W-1:0]          req_cmd,
   input  logic [ppfb_pkg::COORD_W-1:0]        req_x,
   input  logic [ppfb_pkg::COORD_W-1:0]        req_y,
   input  logic [ppfb_pkg::COORD_W-1:0]        req_width,
   input  logic [ppfb_pkg::COORD_W-1:0]        req_height,
   input  logic                                req_color,
   input  logic [ppfb_pkg::STORE_AW-1:0]       req_byte_index,
   output logic                                rsp_valid,
   output logic [ppfb_pkg::DATA_W-1:0]         rsp_read_data
);
   import ppfb_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,     // clearing pass after reset, no result
      S_IDLE,
      S_CLEAR,    // clear command sweep
      S_COL,      // set up one column of a fill
      S_PAGE,     // build page mask, issue RAM read
      S_WR,       // modify and write back
      S_READ      // read data returns
   } state_type;

   localparam int NIB_W = $clog2(DATA_W) + 1;   // holds 0..8

   // ---------------------------------------------------------------
   // Frame store RAM: one write port, one read port, registered read.
   // ---------------------------------------------------------------
   logic [DATA_W-1:0]   mem [STORE_DEPTH];
   logic                mem_we;
   logic [STORE_AW-1:0] mem_waddr;
   logic [DATA_W-1:0]   mem_wdata;
   logic [STORE_AW-1:0] mem_raddr;
   logic [DATA_W-1:0]   mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // ---------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------
   state_type           state_ff,    state_in;
   logic [STORE_AW-1:0] cnt_ff,      cnt_in;
   logic [COORD_W-1:0]  x_ff,        x_in;
   logic [COORD_W-1:0]  y_ff,        y_in;
   logic [COORD_W-1:0]  w_ff,        w_in;
   logic [COORD_W-1:0]  h_ff,        h_in;
   logic                color_ff,    color_in;
   logic [COORD_W-1:0]  dx_ff,       dx_in;
   logic [COORD_W-1:0]  row_ff,      row_in;
   logic [COORD_W-1:0]  rem_ff,      rem_in;
   logic [STORE_AW-1:0] idx_ff,      idx_in;
   logic [DATA_W-1:0]   mask_ff,     mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff,  rsp_data_in;

   // ---------------------------------------------------------------
   // Datapath for the fill walk
   // ---------------------------------------------------------------
   logic [COORD_W-1:0]  col_cur;
   logic                col_ok;
   logic                col_last;
   logic [PAGE_W-1:0]   page_cur;
   logic [2:0]          bit_lo;
   logic [NIB_W-1:0]    avail;
   logic [NIB_W-1:0]    nrows;
   logic [NIB_W-1:0]    bit_hi;
   logic [DATA_W:0]     hi_mask;
   logic [DATA_W-1:0]   span_mask;
   logic [DATA_W-1:0]   panel_mask;
   logic [DATA_W-1:0]   page_mask;
   logic [IDX_W-1:0]    idx_full;
   logic                idx_ok;
   logic [COORD_W-1:0]  row_next;
   logic [COORD_W-1:0]  rem_next;
   logic                accept;

   assign accept   = start && (state_ff == S_IDLE);
   assign col_cur  = x_ff + dx_ff;                                  // wraps mod 256
   assign col_ok   = {1'b0, col_cur} < (COORD_W+1)'(PANEL_WIDTH);
   assign col_last = (dx_ff == (w_ff - 8'd1));

   assign page_cur = row_ff[COORD_W-1:3];
   assign bit_lo   = row_ff[2:0];
   assign avail    = NIB_W'(DATA_W) - {1'b0, bit_lo};
   assign nrows    = (rem_ff < {4'b0, avail}) ? rem_ff[NIB_W-1:0] : avail;
   assign bit_hi   = {1'b0, bit_lo} + nrows;                        // at most 8
   assign hi_mask  = ((DATA_W+1)'(1) << bit_hi) - (DATA_W+1)'(1);
   assign span_mask = (8'hFF << bit_lo) & hi_mask[DATA_W-1:0];

   // rows of this page that lie on the panel
   always_comb begin
      for (int k = 0; k < DATA_W; k++) begin
         panel_mask[k] = {1'b0, page_cur, 3'(k)} < (COORD_W+1)'(PANEL_HEIGHT);
      end
   end

   assign page_mask = span_mask & panel_mask;
   assign idx_full  = IDX_W'(page_cur) * IDX_W'(PANEL_WIDTH) + IDX_W'(col_cur);
   assign idx_ok    = (idx_full[IDX_W-1:STORE_AW] == '0);
   assign row_next  = row_ff + COORD_W'(nrows);
   assign rem_next  = rem_ff - COORD_W'(nrows);

   // ---------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      color_in     = color_ff;
      dx_in        = dx_ff;
      row_in       = row_ff;
      rem_in       = rem_ff;
      idx_in       = idx_ff;
      mask_in      = mask_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      mem_we       = 1'b0;
      mem_waddr    = cnt_ff;
      mem_wdata    = '0;
      mem_raddr    = idx_ff;

      case (state_ff)
         S_INIT, S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               state_in     = S_IDLE;
               rsp_valid_in = (state_ff == S_CLEAR);
            end
         end

         S_IDLE: begin
            mem_raddr = req_byte_index;
            if (start) begin
               x_in     = req_x;
               y_in     = req_y;
               w_in     = req_width;
               h_in     = req_height;
               color_in = req_color;
               dx_in    = '0;
               cnt_in   = '0;
               case (req_cmd)
                  CMD_CLEAR: state_in = S_CLEAR;
                  CMD_READ:  state_in = S_READ;
                  CMD_FILL: begin
                     if (req_width == '0 || req_height == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = S_COL;
                     end
                  end
                  default:   rsp_valid_in = 1'b1;   // unused code: no effect
               endcase
            end
         end

         S_COL: begin
            row_in = y_ff;
            rem_in = h_ff;
            if (col_ok) begin
               state_in = S_PAGE;
            end else if (col_last) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               dx_in = dx_ff + 8'd1;
            end
         end

         S_PAGE: begin
            row_in    = row_next;
            rem_in    = rem_next;
            idx_in    = idx_full[STORE_AW-1:0];
            mask_in   = page_mask;
            mem_raddr = idx_full[STORE_AW-1:0];
            if (page_mask != '0 && idx_ok) begin
               state_in = S_WR;
            end else if (rem_next == '0) begin
               if (col_last) begin
                  state_in     = S_IDLE;
                  rsp_valid_in = 1'b1;
               end else begin
                  dx_in    = dx_ff + 8'd1;
                  state_in = S_COL;
               end
            end
         end

         S_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = color_ff ? (mem_rdata_ff | mask_ff) : (mem_rdata_ff & ~mask_ff);
            if (rem_ff != '0) begin
               state_in = S_PAGE;
            end else if (col_last) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               dx_in    = dx_ff + 8'd1;
               state_in = S_COL;
            end
         end

         S_READ: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            rsp_data_in  = mem_rdata_ff;
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      color_ff    <= color_in;
      dx_ff       <= dx_in;
      row_ff      <= row_in;
      rem_ff      <= rem_in;
      idx_ff      <= idx_in;
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("store written while idle");

   a_wr_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (mask_ff != '0) && (mem_waddr == idx_ff))
      else $error("write-back with empty mask or wrong address");

   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_READ) |=> ##1 rsp_valid)
      else $error("read beat lost");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff != S_IDLE || start) && $past(state_ff != S_INIT))
      else $error("result beat without a command");

   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("command taken before clearing pass");

endmodule
